[hdl/pir_pkg.sv]
`default_nettype none

package pir_pkg;

  // Field and register widths fixed by the interface
  localparam int unsigned DataW        = 32;
  localparam int unsigned RadW         = 31;
  localparam int unsigned CfgAddrW     = 3;
  localparam int unsigned CoordBitsDef = 32;

  // Pipeline depth: front, products, squares, compare/output
  localparam int unsigned NumStages = 4;

  // Reset values of the region registers
  localparam logic [DataW-1:0] ExtReset = 32'd66;
  localparam logic [RadW-1:0]  RadReset = 31'd66;

  typedef enum logic [1:0] {
    SHAPE_BOX    = 2'd0,
    SHAPE_CYL    = 2'd1,
    SHAPE_SPHERE = 2'd2,
    SHAPE_NONE   = 2'd3
  } shape_e;

  typedef enum logic [CfgAddrW-1:0] {
    REG_SHAPE  = 3'd0,
    REG_ORG_X  = 3'd1,
    REG_ORG_Y  = 3'd2,
    REG_ORG_Z  = 3'd3,
    REG_EXT_X  = 3'd4,
    REG_EXT_Y  = 3'd5,
    REG_EXT_Z  = 3'd6,
    REG_RADIUS = 3'd7
  } reg_e;

  // Region configuration
  typedef struct packed {
    shape_e            shape;
    logic [DataW-1:0]  org_x;
    logic [DataW-1:0]  org_y;
    logic [DataW-1:0]  org_z;
    logic [DataW-1:0]  ext_x;
    logic [DataW-1:0]  ext_y;
    logic [DataW-1:0]  ext_z;
    logic [RadW-1:0]   radius;
  } cfg_t;

  // Decision bits carried down the pipe with each item
  typedef struct packed {
    logic base_ok;   // the shape's own span/radius tests pass
    logic rad_need;  // result also needs the squared-distance test
  } ctl_t;

  // Register load enables of the radial stages
  typedef struct packed {
    logic prod;
    logic sq;
    logic cmp;
  } stage_en_t;

  // Magnitude width of a radial operand: coordinate difference or radius
  function automatic int unsigned mag_w(int unsigned cw);
    return (cw + 1 > DataW) ? cw + 1 : DataW;
  endfunction

endpackage

`default_nettype wire

[hdl/pir_front.sv]
`default_nettype none

module pir_front #(
  parameter int unsigned CoordBits = pir_pkg::CoordBitsDef
) (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic                                   kind_i,
  input  logic [pir_pkg::DataW-1:0]              point_x_i,
  input  logic [pir_pkg::DataW-1:0]              point_y_i,
  input  logic [pir_pkg::DataW-1:0]              point_z_i,
  input  logic [pir_pkg::DataW-1:0]              reach_i,
  input  pir_pkg::cfg_t                          cfg_i,
  output pir_pkg::ctl_t                          ctl_o,
  output logic signed [CoordBits:0]              a1_o,
  output logic signed [CoordBits:0]              a2_o,
  output logic signed [CoordBits:0]              a3_o,
  output logic [pir_pkg::mag_w(CoordBits)-1:0]   rr_o
);
  import pir_pkg::*;

  localparam int unsigned CW    = CoordBits;
  localparam int unsigned MagW  = mag_w(CoordBits);
  localparam int unsigned RgW   = ((CW > DataW) ? CW : DataW) + 1;
  localparam int unsigned NumIn = 10;
  localparam int unsigned IPX = 0, IPY = 1, IPZ = 2, IRCH = 3;
  localparam int unsigned IOX = 4, IOY = 5, IOZ = 6;
  localparam int unsigned IEX = 7, IEY = 8, IEZ = 9;

  logic [DataW-1:0]     raw [NumIn];
  logic signed [CW-1:0] crd [NumIn];

  assign raw[IPX]  = point_x_i;
  assign raw[IPY]  = point_y_i;
  assign raw[IPZ]  = point_z_i;
  assign raw[IRCH] = reach_i;
  assign raw[IOX]  = cfg_i.org_x;
  assign raw[IOY]  = cfg_i.org_y;
  assign raw[IOZ]  = cfg_i.org_z;
  assign raw[IEX]  = cfg_i.ext_x;
  assign raw[IEY]  = cfg_i.ext_y;
  assign raw[IEZ]  = cfg_i.ext_z;

  // Read each 32-bit field as a two's complement coordinate of CW bits
  for (genvar i = 0; i < NumIn; i++) begin : g_coord
    if (CW <= DataW) begin : g_narrow
      assign crd[i] = signed'(raw[i][CW-1:0]);
    end else begin : g_wide
      assign crd[i] = signed'({{(CW-DataW){1'b0}}, raw[i]});
    end
  end

  // Open interval test: p + g > o and p - g < o + e
  function automatic logic span(logic signed [CW-1:0] p, logic signed [CW-1:0] o,
                                logic signed [CW-1:0] e, logic signed [CW-1:0] g);
    logic signed [CW:0] pe, oe, ee, ge;
    pe = {p[CW-1], p};
    oe = {o[CW-1], o};
    ee = {e[CW-1], e};
    ge = {g[CW-1], g};
    return ((pe + ge) > oe) && ((pe - ge) < (oe + ee));
  endfunction

  logic signed [CW-1:0] grow, zero_c;
  logic                 box_x, box_y, box_z, cyl_x, cyl_y, cyl_z;
  logic signed [CW:0]   dx, dy, dz;
  logic signed [RgW-1:0] r_ext, rg, rr_sel;
  ctl_t                 ctl_d;
  logic signed [CW:0]   a1_d, a2_d, a3_d;

  assign zero_c = '0;
  assign grow   = kind_i ? crd[IRCH] : zero_c;

  // Per-axis span tests, widened for the box and plain for the cylinder axis
  assign box_x = span(crd[IPX], crd[IOX], crd[IEX], grow);
  assign box_y = span(crd[IPY], crd[IOY], crd[IEY], grow);
  assign box_z = span(crd[IPZ], crd[IOZ], crd[IEZ], grow);
  assign cyl_x = span(crd[IPX], crd[IOX], crd[IEX], zero_c);
  assign cyl_y = span(crd[IPY], crd[IOY], crd[IEY], zero_c);
  assign cyl_z = span(crd[IPZ], crd[IOZ], crd[IEZ], zero_c);

  assign dx = {crd[IPX][CW-1], crd[IPX]} - {crd[IOX][CW-1], crd[IOX]};
  assign dy = {crd[IPY][CW-1], crd[IPY]} - {crd[IOY][CW-1], crd[IOY]};
  assign dz = {crd[IPZ][CW-1], crd[IPZ]} - {crd[IOZ][CW-1], crd[IOZ]};

  // Sphere radius grows by the reach; cylinder radius does not
  assign r_ext = signed'({{(RgW-RadW){1'b0}}, cfg_i.radius});
  assign rg    = r_ext + signed'({{(RgW-CW){grow[CW-1]}}, grow});

  // Shape decode: pick span result and radial operands
  always_comb begin
    ctl_d  = '0;
    a1_d   = dx;
    a2_d   = dy;
    a3_d   = '0;
    rr_sel = r_ext;
    unique case (cfg_i.shape)
      SHAPE_BOX: begin
        ctl_d.base_ok = box_x && box_y && box_z;
      end
      SHAPE_CYL: begin
        ctl_d.rad_need = 1'b1;
        priority if (crd[IEX] != zero_c) begin
          ctl_d.base_ok = cyl_x && (r_ext > 0);
          a1_d = dy;
          a2_d = dz;
        end else if (crd[IEY] != zero_c) begin
          ctl_d.base_ok = cyl_y && (r_ext > 0);
          a1_d = dx;
          a2_d = dz;
        end else if (crd[IEZ] != zero_c) begin
          ctl_d.base_ok = cyl_z && (r_ext > 0);
        end else begin
          ctl_d.base_ok = 1'b0;
        end
      end
      SHAPE_SPHERE: begin
        ctl_d.rad_need = 1'b1;
        ctl_d.base_ok  = rg > 0;
        a3_d   = dz;
        rr_sel = rg;
      end
      SHAPE_NONE: begin
        ctl_d.base_ok = 1'b0;
      end
      default: ctl_d = '0;
    endcase
  end

  // Stage 1 register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_o <= ctl_d;
      a1_o  <= a1_d;
      a2_o  <= a2_d;
      a3_o  <= a3_d;
      rr_o  <= rr_sel[MagW-1:0];
    end
  end

endmodule

`default_nettype wire

[hdl/pir_radial.sv]
`default_nettype none

module pir_radial #(
  parameter int unsigned CoordBits = pir_pkg::CoordBitsDef
) (
  input  logic                                 clk_i,
  input  pir_pkg::stage_en_t                   en_i,
  input  pir_pkg::ctl_t                        ctl_i,
  input  logic signed [CoordBits:0]            a1_i,
  input  logic signed [CoordBits:0]            a2_i,
  input  logic signed [CoordBits:0]            a3_i,
  input  logic [pir_pkg::mag_w(CoordBits)-1:0] rr_i,
  output logic                                 hit_o
);
  import pir_pkg::*;

  localparam int unsigned CW   = CoordBits;
  localparam int unsigned MagW = mag_w(CoordBits);
  localparam int unsigned LoW  = (MagW + 1) / 2;
  localparam int unsigned HiW  = MagW - LoW;
  localparam int unsigned SqW  = 2 * MagW;
  localparam int unsigned SumW = SqW + 2;
  localparam int unsigned NOp  = 4;
  localparam int unsigned IRad = 3;

  logic signed [CW:0] diff [NOp-1];
  logic [MagW-1:0]    op   [NOp];

  assign diff[0] = a1_i;
  assign diff[1] = a2_i;
  assign diff[2] = a3_i;

  // Magnitudes of the differences; radius is already non-negative
  for (genvar k = 0; k < NOp - 1; k++) begin : g_abs
    logic signed [CW:0] neg;
    assign neg   = -diff[k];
    assign op[k] = MagW'(unsigned'(diff[k][CW] ? neg : diff[k]));
  end
  assign op[IRad] = rr_i;

  // Stage 2: partial products of each square
  logic [2*LoW-1:0]   ll_q [NOp];
  logic [HiW+LoW-1:0] hl_q [NOp];
  logic [2*HiW-1:0]   hh_q [NOp];
  ctl_t               ctl2_q;

  for (genvar k = 0; k < NOp; k++) begin : g_prod
    logic [LoW-1:0] lo;
    logic [HiW-1:0] hi;
    assign lo = op[k][LoW-1:0];
    assign hi = op[k][MagW-1:LoW];
    always_ff @(posedge clk_i) begin
      if (en_i.prod) begin
        ll_q[k] <= (2*LoW)'(lo) * (2*LoW)'(lo);
        hl_q[k] <= (HiW+LoW)'(hi) * (HiW+LoW)'(lo);
        hh_q[k] <= (2*HiW)'(hi) * (2*HiW)'(hi);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      ctl2_q <= ctl_i;
    end
  end

  // Stage 3: assemble full squares
  logic [SqW-1:0] sq_q [NOp];
  ctl_t           ctl3_q;

  for (genvar k = 0; k < NOp; k++) begin : g_sq
    always_ff @(posedge clk_i) begin
      if (en_i.sq) begin
        sq_q[k] <= (SqW'(hh_q[k]) << (2 * LoW)) + (SqW'(hl_q[k]) << (LoW + 1))
                 + SqW'(ll_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sq) begin
      ctl3_q <= ctl2_q;
    end
  end

  // Stage 4: squared distance against squared radius
  logic [SumW-1:0] dist_sq;
  logic            closer;

  assign dist_sq = SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
  assign closer  = dist_sq < SumW'(sq_q[IRad]);

  always_ff @(posedge clk_i) begin
    if (en_i.cmp) begin
      hit_o <= ctl3_q.base_ok && (!ctl3_q.rad_need || closer);
    end
  end

endmodule

`default_nettype wire

[hdl/point_in_region_test.sv]
// Point-in-region test: box, axis-aligned cylinder or sphere, Q16.16 coordinates.
// Pipeline stages from input item accept to m_axis_tvalid: front, products,
//   squares, compare; products and squares come from the split squaring multipliers.
// Throughput: one item per cycle; each stage holds an item while the next is full.
// Reset (async, active low) empties the pipe and loads the region registers
//   with their defaults: box at origin, extents 66, radius 66.
`default_nettype none

module point_in_region_test #(
  parameter int unsigned CoordBits = pir_pkg::CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // stream in
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [4*pir_pkg::DataW-1:0]  s_axis_tdata,  // point_x, point_y, point_z, reach
  input  logic [0:0]                   s_axis_tuser,  // kind
  // stream out
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,  // hit, zero pad
  // configuration
  input  logic                         cfg_we_i,
  input  logic [pir_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [pir_pkg::DataW-1:0]    cfg_wdata_i
);
  import pir_pkg::*;

  localparam int unsigned MagW = mag_w(CoordBits);

  // Region registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.shape  <= SHAPE_BOX;
      cfg_q.org_x  <= '0;
      cfg_q.org_y  <= '0;
      cfg_q.org_z  <= '0;
      cfg_q.ext_x  <= ExtReset;
      cfg_q.ext_y  <= ExtReset;
      cfg_q.ext_z  <= ExtReset;
      cfg_q.radius <= RadReset;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_addr_i))
        REG_SHAPE:  cfg_q.shape  <= shape_e'(cfg_wdata_i[1:0]);
        REG_ORG_X:  cfg_q.org_x  <= cfg_wdata_i;
        REG_ORG_Y:  cfg_q.org_y  <= cfg_wdata_i;
        REG_ORG_Z:  cfg_q.org_z  <= cfg_wdata_i;
        REG_EXT_X:  cfg_q.ext_x  <= cfg_wdata_i;
        REG_EXT_Y:  cfg_q.ext_y  <= cfg_wdata_i;
        REG_EXT_Z:  cfg_q.ext_z  <= cfg_wdata_i;
        REG_RADIUS: cfg_q.radius <= cfg_wdata_i[RadW-1:0];
        default:    cfg_q        <= cfg_q;
      endcase
    end
  end

  // Valid bits per stage; a stage loads when empty or when it drains
  logic [NumStages-1:0] vld_q, vld_d, rdy;

  always_comb begin
    rdy[NumStages-1] = !vld_q[NumStages-1] || m_axis_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d[0] = rdy[0] ? s_axis_tvalid : vld_q[0];
    for (int k = 1; k < NumStages; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Datapath
  ctl_t                    ctl1;
  logic signed [CoordBits:0] a1, a2, a3;
  logic [MagW-1:0]         rr;
  stage_en_t               rad_en;
  logic                    hit;

  assign rad_en.prod = rdy[1];
  assign rad_en.sq   = rdy[2];
  assign rad_en.cmp  = rdy[3];

  pir_front #(
    .CoordBits(CoordBits)
  ) u_front (
    .clk_i    (clk_i),
    .en_i     (rdy[0]),
    .kind_i   (s_axis_tuser[0]),
    .point_x_i(s_axis_tdata[DataW-1:0]),
    .point_y_i(s_axis_tdata[2*DataW-1:DataW]),
    .point_z_i(s_axis_tdata[3*DataW-1:2*DataW]),
    .reach_i  (s_axis_tdata[4*DataW-1:3*DataW]),
    .cfg_i    (cfg_q),
    .ctl_o    (ctl1),
    .a1_o     (a1),
    .a2_o     (a2),
    .a3_o     (a3),
    .rr_o     (rr)
  );

  pir_radial #(
    .CoordBits(CoordBits)
  ) u_radial (
    .clk_i(clk_i),
    .en_i (rad_en),
    .ctl_i(ctl1),
    .a1_i (a1),
    .a2_i (a2),
    .a3_i (a3),
    .rr_i (rr),
    .hit_o(hit)
  );

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[NumStages-1];
  assign m_axis_tdata  = {7'b0, hit};

`ifndef SYNTHESIS
  // An accepted item always lands in the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted item not captured in stage 1");

  // An item leaves stage 1 only into a stage that could take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(vld_q[0]) |-> $past(rdy[1]))
    else $error("item dropped from stage 1");

  // A finished item moves to the output register when it is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] && rdy[3] |=> vld_q[3])
    else $error("item lost between stage 3 and output");

  // Output valid never drops without a completed transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(vld_q[3]) |-> $past(m_axis_tready))
    else $error("result withdrawn before it was taken");
`endif

endmodule

`default_nettype wire
